// File: design/assert_macros.svh
// Assertion macros used by the RTL file jpeg_header_size_scanner.sv.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: design/jhss_pkg.sv
// Types and constants for the JPEG header size scanner.
// No dependencies.
package jhss_pkg;

    localparam int unsigned PREFIX_SKIP_DEF       = 2;
    localparam int unsigned FRAME_HEADER_SKIP_DEF = 3;

    localparam int unsigned SKIP_W = 16;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    typedef enum logic [11:0] {
        PH_PREFIX   = 12'b0000_0000_0001,
        PH_HUNT     = 12'b0000_0000_0010,
        PH_FILL     = 12'b0000_0000_0100,
        PH_LEN_HI   = 12'b0000_0000_1000,
        PH_LEN_LO   = 12'b0000_0001_0000,
        PH_PAYLOAD  = 12'b0000_0010_0000,
        PH_SOF_SKIP = 12'b0000_0100_0000,
        PH_H_HI     = 12'b0000_1000_0000,
        PH_H_LO     = 12'b0001_0000_0000,
        PH_W_HI     = 12'b0010_0000_0000,
        PH_W_LO     = 12'b0100_0000_0000,
        PH_DONE     = 12'b1000_0000_0000
    } t_phase;

endpackage

// File: design/jpeg_header_size_scanner.sv
// JPEG header size scanner: finds the frame size in a byte stream.
// Depends on jhss_pkg and assert_macros.svh.
//
//  channel  | dir | fields (low bit up)
//  ---------+-----+-------------------------------------------
//  s_axis   | in  | tdata: data_byte[7:0]; tlast: last_byte
//  m_axis   | out | tdata: width[15:0], height[31:16]; tuser: status
//
// One byte per cycle while s_axis_tready is high: each item updates the phase
// machine and counters in the cycle it is accepted. A result is registered in
// the output register as its byte is accepted. s_axis_tready drops only while
// that register holds a result that m_axis does not take. Synchronous active-low
// reset and a file's last byte go to the prefix skip (hunt if PREFIX_SKIP=0).
`include "assert_macros.svh"

module jpeg_header_size_scanner #(
    parameter int unsigned PREFIX_SKIP       = jhss_pkg::PREFIX_SKIP_DEF,
    parameter int unsigned FRAME_HEADER_SKIP = jhss_pkg::FRAME_HEADER_SKIP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // width[15:0], height[31:16]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam jhss_pkg::t_phase RST_PHASE =
        (PREFIX_SKIP != 0) ? jhss_pkg::PH_PREFIX : jhss_pkg::PH_HUNT;
    localparam logic [jhss_pkg::SKIP_W-1:0] PREFIX_CNT = jhss_pkg::SKIP_W'(PREFIX_SKIP);
    localparam logic [jhss_pkg::SKIP_W-1:0] SOF_CNT    = jhss_pkg::SKIP_W'(FRAME_HEADER_SKIP);

    jhss_pkg::t_phase              r_phase, n_phase;
    logic [jhss_pkg::SKIP_W-1:0]   r_skip, n_skip;
    logic [7:0]                    r_len_hi, n_len_hi;
    logic [15:0]                   r_height, n_height;
    logic [15:0]                   r_width, n_width;

    logic                          r_out_valid;
    logic [31:0]                   r_out_data;
    logic [1:0]                    r_out_status;

    logic                          w_accept;
    logic                          w_res_valid;
    logic [1:0]                    w_res_status;
    logic [31:0]                   w_res_data;
    logic [15:0]                   w_len;
    logic                          w_done;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_len         = {r_len_hi, s_axis_tdata};

    always_comb begin
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_len_hi     = r_len_hi;
        n_height     = r_height;
        n_width      = r_width;
        w_res_valid  = 1'b0;
        w_res_status = jhss_pkg::ST_FOUND;
        w_res_data   = '0;

        unique case (r_phase)
            jhss_pkg::PH_PREFIX, jhss_pkg::PH_PAYLOAD, jhss_pkg::PH_SOF_SKIP: begin
                if (r_skip > jhss_pkg::SKIP_W'(1)) begin
                    n_skip = r_skip - jhss_pkg::SKIP_W'(1);
                end else begin
                    n_skip  = '0;
                    n_phase = (r_phase == jhss_pkg::PH_SOF_SKIP) ? jhss_pkg::PH_H_HI
                                                                 : jhss_pkg::PH_HUNT;
                end
            end
            jhss_pkg::PH_HUNT: begin
                if (s_axis_tdata == jhss_pkg::MK_PREFIX) n_phase = jhss_pkg::PH_FILL;
            end
            jhss_pkg::PH_FILL: begin
                // fill bytes keep us here; anything else is the marker type
                if (s_axis_tdata != jhss_pkg::MK_PREFIX) begin
                    unique case (s_axis_tdata) inside
                        jhss_pkg::MK_STUFF, jhss_pkg::MK_TEM,
                        [jhss_pkg::MK_RST0:jhss_pkg::MK_RST7]: begin
                            n_phase = jhss_pkg::PH_HUNT;
                        end
                        jhss_pkg::MK_SOF0, jhss_pkg::MK_SOF2: begin
                            if (FRAME_HEADER_SKIP != 0) begin
                                n_skip  = SOF_CNT;
                                n_phase = jhss_pkg::PH_SOF_SKIP;
                            end else begin
                                n_phase = jhss_pkg::PH_H_HI;
                            end
                        end
                        jhss_pkg::MK_SOS: begin
                            n_phase      = jhss_pkg::PH_DONE;
                            w_res_valid  = 1'b1;
                            w_res_status = jhss_pkg::ST_SCAN;
                        end
                        default: begin
                            n_phase = jhss_pkg::PH_LEN_HI;
                        end
                    endcase
                end
            end
            jhss_pkg::PH_LEN_HI: begin
                n_len_hi = s_axis_tdata;
                n_phase  = jhss_pkg::PH_LEN_LO;
            end
            jhss_pkg::PH_LEN_LO: begin
                // length counts its own two bytes; skip only the payload
                if (w_len > 16'd2) begin
                    n_skip  = jhss_pkg::SKIP_W'(w_len - 16'd2);
                    n_phase = jhss_pkg::PH_PAYLOAD;
                end else begin
                    n_phase = jhss_pkg::PH_HUNT;
                end
            end
            jhss_pkg::PH_H_HI: begin
                n_height = {s_axis_tdata, 8'h00};
                n_phase  = jhss_pkg::PH_H_LO;
            end
            jhss_pkg::PH_H_LO: begin
                n_height = {r_height[15:8], s_axis_tdata};
                n_phase  = jhss_pkg::PH_W_HI;
            end
            jhss_pkg::PH_W_HI: begin
                n_width = {s_axis_tdata, 8'h00};
                n_phase = jhss_pkg::PH_W_LO;
            end
            jhss_pkg::PH_W_LO: begin
                n_width     = {r_width[15:8], s_axis_tdata};
                n_phase     = jhss_pkg::PH_DONE;
                w_res_valid = 1'b1;
                w_res_data  = {r_height, r_width[15:8], s_axis_tdata};
            end
            default: begin
                n_phase = jhss_pkg::PH_DONE;
            end
        endcase

        w_done = (n_phase == jhss_pkg::PH_DONE);

        if (s_axis_tlast) begin
            if (!w_done) begin
                w_res_valid  = 1'b1;
                w_res_status = jhss_pkg::ST_END;
                w_res_data   = '0;
            end
            // end of file: start over for the next one
            n_phase  = RST_PHASE;
            n_skip   = PREFIX_CNT;
            n_len_hi = '0;
            n_height = '0;
            n_width  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= RST_PHASE;
            r_skip      <= PREFIX_CNT;
            r_len_hi    <= '0;
            r_height    <= '0;
            r_width     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_skip   <= n_skip;
                r_len_hi <= n_len_hi;
                r_height <= n_height;
                r_width  <= n_width;
            end
            if (w_accept && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out_data   <= w_res_data;
            r_out_status <= w_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    `ASSERT_CLK(a_last_restarts, w_accept && s_axis_tlast |=> r_phase == RST_PHASE, "last item did not restart the scan")
    `ASSERT_CLK(a_one_result, w_accept && r_phase == jhss_pkg::PH_DONE && !s_axis_tlast |-> !w_res_valid, "second result in one file")
    `ASSERT_CLK(a_zero_if_missing, r_out_valid && r_out_status != jhss_pkg::ST_FOUND |-> r_out_data == 32'd0, "size not zero without a frame header")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

// File: tb/jpeg_header_size_scanner_test.sv
// Self-checking bench for jpeg_header_size_scanner: directed files, then random JPEG-like files.
// Depends on jhss_pkg for marker codes, phase encoding and status codes.
`timescale 1ns / 100ps

module jpeg_header_size_scanner_test;

    localparam int BYTE_TARGET = 1600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIR       = 24;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  status;
    } t_size_rep;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_size_rep  rep;
    } t_dir_row;

    // Three short files: scan start on the last byte, cut in a short segment length,
    // and an all-ones frame size whose last width byte ends the file.
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hDA, 1'b1, 1'b1, '{16'h0000, 16'h0000, jhss_pkg::ST_SCAN}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hD8, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b1, '{16'h0000, 16'h0000, jhss_pkg::ST_END}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hD8, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h11, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{16'hFFFF, 16'hFFFF, jhss_pkg::ST_FOUND}}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // data_byte[7:0]
    logic        s_axis_tlast  = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // width[15:0], height[31:16]
    logic [1:0]  m_axis_tuser;            // status[1:0]

    // scanner state mirrored by the predictor
    jhss_pkg::t_phase scan_ph;
    logic [15:0] skip_left;
    logic [7:0]  len_msb;
    logic [15:0] h_acc;
    logic [15:0] w_acc;
    logic        finished;
    logic        sos_hit;

    t_size_rep   pending_sizes[$];
    logic [7:0]  file_q[$];
    t_size_rep   got_rep;
    t_size_rep   want_rep;
    int          err_count   = 0;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          files_sent  = 0;
    int          status_seen[3] = '{0, 0, 0};
    bit          steady = 1'b0;

    jpeg_header_size_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic void scanner_clear();
        scan_ph   = (jhss_pkg::PREFIX_SKIP_DEF != 0) ? jhss_pkg::PH_PREFIX : jhss_pkg::PH_HUNT;
        skip_left = 16'(jhss_pkg::PREFIX_SKIP_DEF);
        len_msb   = 8'h00;
        h_acc     = 16'h0000;
        w_acc     = 16'h0000;
        finished  = 1'b0;
        sos_hit   = 1'b0;
    endfunction

    // Advance the scanner by one byte; return 1 when the byte yields a size report.
    function automatic bit scan_byte(input logic [7:0] b, input logic last, output t_size_rep rep);
        logic        was_done;
        logic [15:0] seg_len;
        bit          got;
        was_done = finished;
        got      = 1'b0;
        rep      = '0;
        case (scan_ph)
            jhss_pkg::PH_PREFIX, jhss_pkg::PH_PAYLOAD, jhss_pkg::PH_SOF_SKIP: begin
                if (skip_left > 16'd1) begin
                    skip_left--;
                end else begin
                    skip_left = 16'd0;
                    scan_ph   = (scan_ph == jhss_pkg::PH_SOF_SKIP) ? jhss_pkg::PH_H_HI
                                                                   : jhss_pkg::PH_HUNT;
                end
            end
            jhss_pkg::PH_HUNT: begin
                if (b == jhss_pkg::MK_PREFIX) scan_ph = jhss_pkg::PH_FILL;
            end
            jhss_pkg::PH_FILL: begin
                // fill bytes keep us here; the first other byte is the marker type
                if (b == jhss_pkg::MK_PREFIX) begin
                    scan_ph = jhss_pkg::PH_FILL;
                end else if (b == jhss_pkg::MK_STUFF || b == jhss_pkg::MK_TEM ||
                             (b >= jhss_pkg::MK_RST0 && b <= jhss_pkg::MK_RST7)) begin
                    scan_ph = jhss_pkg::PH_HUNT;
                end else if (b == jhss_pkg::MK_SOF0 || b == jhss_pkg::MK_SOF2) begin
                    if (jhss_pkg::FRAME_HEADER_SKIP_DEF != 0) begin
                        skip_left = 16'(jhss_pkg::FRAME_HEADER_SKIP_DEF);
                        scan_ph   = jhss_pkg::PH_SOF_SKIP;
                    end else begin
                        scan_ph = jhss_pkg::PH_H_HI;
                    end
                end else if (b == jhss_pkg::MK_SOS) begin
                    sos_hit  = 1'b1;
                    finished = 1'b1;
                    scan_ph  = jhss_pkg::PH_DONE;
                end else begin
                    scan_ph = jhss_pkg::PH_LEN_HI;
                end
            end
            jhss_pkg::PH_LEN_HI: begin
                len_msb = b;
                scan_ph = jhss_pkg::PH_LEN_LO;
            end
            jhss_pkg::PH_LEN_LO: begin
                seg_len = {len_msb, b};
                if (seg_len > 16'd2) begin
                    skip_left = seg_len - 16'd2;
                    scan_ph   = jhss_pkg::PH_PAYLOAD;
                end else begin
                    scan_ph = jhss_pkg::PH_HUNT;
                end
            end
            jhss_pkg::PH_H_HI: begin
                h_acc   = {b, 8'h00};
                scan_ph = jhss_pkg::PH_H_LO;
            end
            jhss_pkg::PH_H_LO: begin
                h_acc   = {h_acc[15:8], b};
                scan_ph = jhss_pkg::PH_W_HI;
            end
            jhss_pkg::PH_W_HI: begin
                w_acc   = {b, 8'h00};
                scan_ph = jhss_pkg::PH_W_LO;
            end
            jhss_pkg::PH_W_LO: begin
                w_acc    = {w_acc[15:8], b};
                finished = 1'b1;
                scan_ph  = jhss_pkg::PH_DONE;
            end
            default: scan_ph = jhss_pkg::PH_DONE;
        endcase

        if (!was_done && finished) begin
            if (sos_hit) rep = t_size_rep'{16'h0000, 16'h0000, jhss_pkg::ST_SCAN};
            else         rep = t_size_rep'{w_acc, h_acc, jhss_pkg::ST_FOUND};
            got = 1'b1;
        end else if (!finished && last) begin
            rep = t_size_rep'{16'h0000, 16'h0000, jhss_pkg::ST_END};
            got = 1'b1;
        end
        if (last) scanner_clear();
        return got;
    endfunction

    // Present one byte, wait for the handshake, then queue whatever it should produce.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_size_rep typed_rep);
        t_size_rep rep;
        bit        got;
        if (!steady && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = scan_byte(b, last, rep);
        if (typed) pending_sizes.push_back(typed_rep);
        else if (got) pending_sizes.push_back(rep);
        bytes_sent++;
        if (last) files_sent++;
    endtask

    // Build a file: prefix, a few segments, then a frame header or scan start,
    // sometimes cut short; one in ten files is plain noise.
    task automatic make_file();
        logic [7:0] mtype;
        int         seg_len;
        int         cut;
        file_q.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 24))
                file_q.push_back(($urandom_range(3) == 0) ? jhss_pkg::MK_PREFIX : 8'($urandom));
            return;
        end
        file_q.push_back(($urandom_range(3) == 0) ? 8'($urandom) : jhss_pkg::MK_PREFIX);
        file_q.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'hD8);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(5))
                0: file_q.push_back(8'($urandom_range(254)));
                1: begin
                    repeat ($urandom_range(1, 3)) file_q.push_back(jhss_pkg::MK_PREFIX);
                    file_q.push_back($urandom_range(1) ? jhss_pkg::MK_STUFF : jhss_pkg::MK_TEM);
                end
                2: begin
                    file_q.push_back(jhss_pkg::MK_PREFIX);
                    file_q.push_back(jhss_pkg::MK_RST0 + 8'($urandom_range(7)));
                end
                default: begin
                    mtype = 8'($urandom);
                    if (mtype == jhss_pkg::MK_PREFIX || mtype == jhss_pkg::MK_STUFF ||
                        mtype == jhss_pkg::MK_TEM ||
                        (mtype >= jhss_pkg::MK_RST0 && mtype <= jhss_pkg::MK_RST7) ||
                        mtype == jhss_pkg::MK_SOF0 || mtype == jhss_pkg::MK_SOF2 ||
                        mtype == jhss_pkg::MK_SOS)
                        mtype = 8'hE1;
                    file_q.push_back(jhss_pkg::MK_PREFIX);
                    file_q.push_back(mtype);
                    case ($urandom_range(11))
                        0, 1: seg_len = $urandom_range(0, 2);
                        2:    seg_len = $urandom_range(256, 767);
                        default: seg_len = $urandom_range(3, 12);
                    endcase
                    file_q.push_back(8'(seg_len >> 8));
                    file_q.push_back(8'(seg_len));
                    repeat ((seg_len > 2) ? seg_len - 2 : 0) file_q.push_back(8'($urandom));
                end
            endcase
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) file_q.push_back(jhss_pkg::MK_PREFIX);
            file_q.push_back(jhss_pkg::MK_SOS);
        end else begin
            file_q.push_back(jhss_pkg::MK_PREFIX);
            file_q.push_back($urandom_range(1) ? jhss_pkg::MK_SOF0 : jhss_pkg::MK_SOF2);
            repeat (3) file_q.push_back(8'($urandom));
            // size bytes lean toward the extremes
            repeat (4) begin
                case ($urandom_range(5))
                    0: file_q.push_back(8'h00);
                    1: file_q.push_back(8'hFF);
                    default: file_q.push_back(8'($urandom));
                endcase
            end
        end
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
    endtask

    // stimulus
    initial begin
        scanner_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++)
            send_byte(DIR_ROWS[r].data, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].rep);

        while (bytes_sent < BYTE_TARGET) begin
            make_file();
            foreach (file_q[k]) begin
                // hold both sides busy for a stretch in the middle of the run
                steady = (bytes_sent >= 700 && bytes_sent < 1000);
                send_byte(file_q[k], k == file_q.size() - 1, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (pending_sizes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d files.", bytes_sent, files_sent);
        $display("Reports checked: %0d size found, %0d scan start, %0d file ended.",
                 status_seen[jhss_pkg::ST_FOUND], status_seen[jhss_pkg::ST_SCAN],
                 status_seen[jhss_pkg::ST_END]);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end

    // compare each taken report with the oldest one queued
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rep = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
            if (pending_sizes.size() == 0) begin
                report_mismatch($sformatf("unexpected report w=%0d h=%0d status=%0d",
                                          got_rep.width, got_rep.height, got_rep.status));
            end else begin
                want_rep = pending_sizes.pop_front();
                if (got_rep.width != want_rep.width)
                    report_mismatch($sformatf("width %0d, want %0d",
                                              got_rep.width, want_rep.width));
                if (got_rep.height != want_rep.height)
                    report_mismatch($sformatf("height %0d, want %0d",
                                              got_rep.height, want_rep.height));
                if (got_rep.status != want_rep.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got_rep.status, want_rep.status));
                if (want_rep.status <= jhss_pkg::ST_END) status_seen[want_rep.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_sizes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
